// ----- hw/rtl/skf_pkg.sv -----
// skf_pkg: widths, reset values, register codes and shared types of the scalar Kalman filter
// no dependencies; used by every other file of the block through scoped names

package skf_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CH_W         = 2;
   localparam int SAMPLE_W     = 16;
   localparam int EST_W        = 32;
   localparam int REG_W        = 17;
   localparam int COV_W        = 17;
   localparam int N_W          = 18;
   localparam int D_W          = 19;
   localparam int GAIN_W       = 17;
   localparam int DIFF_W       = 33;
   localparam int FRAC_W       = 16;
   localparam int MUL_W        = 19;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int DIV_STEPS    = GAIN_W;
   localparam int CNT_W        = $clog2(DIV_STEPS);
   localparam int ADDR_W       = 3;
   localparam int DATA_W       = 32;

   localparam logic [COV_W-1:0]  ONE_Q16           = 17'h10000;
   localparam logic [COV_W-1:0]  COV_MAX           = 17'h1FFFF;
   localparam logic [REG_W-1:0]  PROCESS_NOISE_RST = 17'd655;
   localparam logic [REG_W-1:0]  MEASURE_NOISE_RST = 17'd13107;

   localparam logic REG_PROCESS_NOISE = 1'b0;
   localparam logic REG_MEASURE_NOISE = 1'b1;

   localparam logic ACTION_FILTER = 1'b0;
   localparam logic ACTION_INIT   = 1'b1;

   typedef struct packed {
      logic [REG_W-1:0] process_noise;
      logic [REG_W-1:0] measure_noise;
   } cfg_type;

endpackage

// ----- hw/rtl/skf_req_if.sv -----
// skf_req_if: input beat channel of the scalar Kalman filter (valid/ready plus sample payload)
// depends on skf_pkg for field widths

interface skf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [skf_pkg::CH_W-1:0]         channel;
   logic signed [skf_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output action, output channel, output sample, input ready);
   modport sink   (input valid, input action, input channel, input sample, output ready);
endinterface

// ----- hw/rtl/skf_rsp_if.sv -----
// skf_rsp_if: result beat channel of the scalar Kalman filter (valid/ready plus estimate)
// depends on skf_pkg for field widths

interface skf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [skf_pkg::CH_W-1:0]          channel_out;
   logic signed [skf_pkg::EST_W-1:0]  estimate;

   modport source (output valid, output channel_out, output estimate, input ready);
   modport sink   (input valid, input channel_out, input estimate, output ready);
endinterface

// ----- hw/rtl/skf_csr.sv -----
// skf_csr: apb-style register file holding the process and measurement noise settings
// depends on skf_pkg for register codes, reset values and cfg_type

module skf_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [skf_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [skf_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [skf_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output skf_pkg::cfg_type             cfg
);

   logic [skf_pkg::REG_W-1:0] process_noise_ff, process_noise_in;
   logic [skf_pkg::REG_W-1:0] measure_noise_ff, measure_noise_in;
   logic                      wr_en;
   logic                      reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      process_noise_in = process_noise_ff;
      measure_noise_in = measure_noise_ff;
      csr_prdata       = '0;
      case (reg_sel)
         skf_pkg::REG_PROCESS_NOISE: begin
            if (wr_en) begin
               process_noise_in = csr_pwdata[skf_pkg::REG_W-1:0];
            end
            csr_prdata = {{(skf_pkg::DATA_W-skf_pkg::REG_W){1'b0}}, process_noise_ff};
         end
         skf_pkg::REG_MEASURE_NOISE: begin
            if (wr_en) begin
               measure_noise_in = csr_pwdata[skf_pkg::REG_W-1:0];
            end
            csr_prdata = {{(skf_pkg::DATA_W-skf_pkg::REG_W){1'b0}}, measure_noise_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= skf_pkg::PROCESS_NOISE_RST;
         measure_noise_ff <= skf_pkg::MEASURE_NOISE_RST;
      end else begin
         process_noise_ff <= process_noise_in;
         measure_noise_ff <= measure_noise_in;
      end
   end

   assign cfg.process_noise = process_noise_ff;
   assign cfg.measure_noise = measure_noise_ff;

endmodule

// ----- hw/rtl/skf_div.sv -----
// skf_div: restoring divider, one quotient bit per cycle, gain = floor(num * 2^16 / den)
// depends on skf_pkg for widths; quotient is zero when den is zero

module skf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [skf_pkg::N_W-1:0]      num,
   input  logic [skf_pkg::D_W-1:0]      den,
   output logic                         busy,
   output logic                         done,
   output logic [skf_pkg::GAIN_W-1:0]   quot
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [skf_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [skf_pkg::D_W-1:0]        rem_ff, rem_in;
   logic [skf_pkg::D_W-1:0]        den_ff, den_in;
   logic [skf_pkg::GAIN_W-1:0]     bits_ff, bits_in;
   logic [skf_pkg::GAIN_W-1:0]     quot_ff, quot_in;
   logic [skf_pkg::D_W:0]          trial;
   logic [skf_pkg::D_W:0]          trial_sub;
   logic                           fits;

   always_comb begin
      trial     = {rem_ff, bits_ff[skf_pkg::GAIN_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;

      if (start) begin
         // numerator msbs seed the remainder, its lsb is the first bit shifted in
         busy_in = 1'b1;
         cnt_in  = skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);
         rem_in  = {{(skf_pkg::D_W-skf_pkg::N_W+1){1'b0}}, num[skf_pkg::N_W-1:1]};
         bits_in = {num[0], {(skf_pkg::GAIN_W-1){1'b0}}};
         den_in  = den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[skf_pkg::D_W-1:0] : trial[skf_pkg::D_W-1:0];
         bits_in = {bits_ff[skf_pkg::GAIN_W-2:0], 1'b0};
         quot_in = {quot_ff[skf_pkg::GAIN_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = (den_ff == '0) ? '0 : quot_ff;

endmodule

// ----- hw/rtl/scalar_kalman_filter.sv -----
// scalar_kalman_filter: per-channel 1-d kalman filter, q16.16 estimate, q1.16 covariance
// filter beat: prep, then the bit-serial divider, then mlo, mhi, mp, fin and done
// init beat or channel out of range: no div; one beat in work at a time, ready only when idle
// a finished result waits in the output register while the next beat is accepted
// reset: synchronous, estimates to 0, covariances to 1.0, noise registers to q 655, r 13107
// depends on skf_pkg, skf_req_if, skf_rsp_if, skf_csr, skf_div

module scalar_kalman_filter #(
   parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   skf_req_if.sink                      req_port,
   skf_rsp_if.source                    rsp_port,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [skf_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [skf_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [skf_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_PREP = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_MLO  = 8'b0000_1000,
      S_MHI  = 8'b0001_0000,
      S_MP   = 8'b0010_0000,
      S_FIN  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   skf_pkg::cfg_type cfg;

   state_type                              state_ff, state_in;
   logic                                   action_ff, action_in;
   logic [skf_pkg::CH_W-1:0]               ch_ff, ch_in;
   logic [skf_pkg::SAMPLE_W-1:0]           sample_ff, sample_in;
   logic [skf_pkg::N_W-1:0]                n_ff, n_in;
   logic [skf_pkg::EST_W-1:0]              est_ff, est_in;
   logic [skf_pkg::DIFF_W-1:0]             diff_ff, diff_in;
   logic [skf_pkg::GAIN_W-1:0]             gain_ff, gain_in;
   logic signed [skf_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [skf_pkg::FRAC_W-1:0]             acc_ff, acc_in;
   logic [skf_pkg::EST_W-1:0]              res_ff, res_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [skf_pkg::CH_W-1:0]               rsp_ch_ff, rsp_ch_in;
   logic [skf_pkg::EST_W-1:0]              rsp_est_ff, rsp_est_in;

   logic [skf_pkg::EST_W-1:0]              est_store_ff [CHANNELS];
   logic [skf_pkg::COV_W-1:0]              cov_store_ff [CHANNELS];
   logic                                   st_we;
   logic [skf_pkg::EST_W-1:0]              st_est;
   logic [skf_pkg::COV_W-1:0]              st_cov;

   logic [IDX_W-1:0]                       idx;
   logic                                   in_range;
   logic [skf_pkg::EST_W-1:0]              target;
   logic [skf_pkg::N_W-1:0]                n_calc;
   logic [skf_pkg::D_W-1:0]                d_calc;
   logic                                   div_start;
   logic                                   div_busy;
   logic                                   div_done;
   logic [skf_pkg::GAIN_W-1:0]             div_quot;
   logic signed [skf_pkg::MUL_W-1:0]       mul_a;
   logic signed [skf_pkg::MUL_W-1:0]       mul_b;
   logic signed [skf_pkg::PROD_W-1:0]      mul_p;
   logic [skf_pkg::PROD_W-1:0]             sum;
   logic [skf_pkg::N_W-1:0]                p_full;
   logic [skf_pkg::COV_W-1:0]              p_sat;
   logic                                   req_take;
   logic                                   rsp_free;

   skf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   skf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (n_calc),
      .den   (d_calc),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid & req_port.ready;
   assign rsp_free       = ~rsp_valid_ff | rsp_port.ready;

   assign idx      = IDX_W'(ch_ff);
   assign in_range = (int'(ch_ff) < CHANNELS);
   assign target   = {sample_ff, {skf_pkg::FRAC_W{1'b0}}};
   assign n_calc   = skf_pkg::N_W'(cov_store_ff[idx]) + skf_pkg::N_W'(cfg.process_noise);
   assign d_calc   = skf_pkg::D_W'(n_calc) + skf_pkg::D_W'(cfg.measure_noise);
   assign div_start = (state_ff == S_PREP) & in_range & (action_ff == skf_pkg::ACTION_FILTER);

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      case (state_ff)
         S_MLO: begin
            mul_a = $signed({2'b00, gain_ff});
            mul_b = $signed({3'b000, diff_ff[skf_pkg::FRAC_W-1:0]});
         end
         S_MHI: begin
            mul_a = $signed({2'b00, gain_ff});
            mul_b = $signed({{2{diff_ff[skf_pkg::DIFF_W-1]}},
                             diff_ff[skf_pkg::DIFF_W-1:skf_pkg::FRAC_W]});
         end
         S_MP: begin
            mul_a = $signed({2'b00, skf_pkg::ONE_Q16 - gain_ff});
            mul_b = $signed({1'b0, n_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign sum    = {{(skf_pkg::PROD_W-skf_pkg::EST_W){est_ff[skf_pkg::EST_W-1]}}, est_ff}
                 + prod_ff
                 + {{(skf_pkg::PROD_W-skf_pkg::FRAC_W){1'b0}}, acc_ff};
   assign p_full = prod_ff[skf_pkg::FRAC_W+skf_pkg::N_W-1:skf_pkg::FRAC_W];
   assign p_sat  = (p_full > skf_pkg::N_W'(skf_pkg::COV_MAX))
                 ? skf_pkg::COV_MAX : p_full[skf_pkg::COV_W-1:0];

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      n_in         = n_ff;
      est_in       = est_ff;
      diff_in      = diff_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_port.ready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_est_in   = rsp_est_ff;
      st_we        = 1'b0;
      st_est       = target;
      st_cov       = skf_pkg::ONE_Q16;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               action_in = req_port.action;
               ch_in     = req_port.channel;
               sample_in = req_port.sample;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (!in_range) begin
               res_in   = '0;
               state_in = S_DONE;
            end else if (action_ff == skf_pkg::ACTION_INIT) begin
               st_we    = 1'b1;
               res_in   = target;
               state_in = S_DONE;
            end else begin
               n_in     = n_calc;
               est_in   = est_store_ff[idx];
               diff_in  = {target[skf_pkg::EST_W-1], target}
                        - {est_store_ff[idx][skf_pkg::EST_W-1], est_store_ff[idx]};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               gain_in  = div_quot;
               state_in = S_MLO;
            end
         end
         S_MLO: begin
            prod_in  = mul_p;
            state_in = S_MHI;
         end
         S_MHI: begin
            // gain times the low half is never negative, so its floor is a plain shift
            acc_in   = prod_ff[2*skf_pkg::FRAC_W-1:skf_pkg::FRAC_W];
            prod_in  = mul_p;
            state_in = S_MP;
         end
         S_MP: begin
            est_in   = sum[skf_pkg::EST_W-1:0];
            prod_in  = mul_p;
            state_in = S_FIN;
         end
         S_FIN: begin
            st_we    = 1'b1;
            st_est   = est_ff;
            st_cov   = p_sat;
            res_in   = est_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_est_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      ch_ff      <= ch_in;
      sample_ff  <= sample_in;
      n_ff       <= n_in;
      est_ff     <= est_in;
      diff_ff    <= diff_in;
      gain_ff    <= gain_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      rsp_ch_ff  <= rsp_ch_in;
      rsp_est_ff <= rsp_est_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            est_store_ff[i] <= '0;
            cov_store_ff[i] <= skf_pkg::ONE_Q16;
         end
      end else if (st_we) begin
         est_store_ff[idx] <= st_est;
         cov_store_ff[idx] <= st_cov;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.channel_out = rsp_ch_ff;
   assign rsp_port.estimate    = rsp_est_ff;

`ifndef SYNTHESIS
   a_take_starts_prep: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_PREP))
      else $error("accepted beat did not enter prep");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      (div_done || div_busy) |-> (state_ff == S_DIV))
      else $error("divider active outside the divide state");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished result not moved to the output register");
`endif

endmodule
